// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the median filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define IMF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("median filter assertion failed");

// next-cycle implication, checked outside reset
`define IMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("median filter assertion failed");

`endif

// ----- rtl/imf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_pkg
// Types and fixed constants shared by the median filter modules.
// ----------------------------------------------------------------------------
package imf_pkg;

    localparam int PIX_W     = 8;   // pixel and coordinate field width
    localparam int CNT_W     = 6;   // window count width
    localparam int OFS_W     = 4;   // signed window offset, covers radius up to 7
    localparam int CRD_W     = 10;  // signed coordinate after adding an offset
    localparam int RAD_W     = 2;   // radius register width
    localparam int RAD_LIMIT = 3;   // largest radius the register can hold

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_sort_ctl;

endpackage

// ----- rtl/imf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/imf_sort.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_sort
// Row of compare cells holding the window pixels in ascending order.
// One pixel is inserted per cycle; shift drops the smallest entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imf_sort #(
    parameter int BUF_N = 49
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  imf_pkg::t_sort_ctl         i_ctl,
    input  logic [imf_pkg::PIX_W-1:0]  i_din,
    output logic [imf_pkg::PIX_W-1:0]  o_head
);

    logic [imf_pkg::PIX_W-1:0] r_buf [BUF_N];
    logic [imf_pkg::PIX_W-1:0] n_buf [BUF_N];
    logic [imf_pkg::CNT_W-1:0] r_fill;
    logic [imf_pkg::CNT_W-1:0] n_fill;
    logic [BUF_N-1:0]          le;

    // le marks the filled prefix of entries not above the new pixel
    always_comb begin
        for (int i = 0; i < BUF_N; i++) begin
            le[i] = (imf_pkg::CNT_W'(i) < r_fill) && (r_buf[i] <= i_din);
        end
    end

    always_comb begin
        n_buf  = r_buf;
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.insert) begin
            n_fill   = r_fill + imf_pkg::CNT_W'(1);
            n_buf[0] = le[0] ? r_buf[0] : i_din;
            for (int i = 1; i < BUF_N; i++) begin
                if (le[i]) begin
                    n_buf[i] = r_buf[i];
                end else if (le[i-1]) begin
                    n_buf[i] = i_din;
                end else begin
                    n_buf[i] = r_buf[i-1];
                end
            end
        end else if (i_ctl.shift) begin
            for (int i = 0; i < BUF_N - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_head = r_buf[0];

    `IMF_ASSERT_IMP(a_sort_no_overflow, i_clk, i_rst_n, i_ctl.insert, r_fill < imf_pkg::CNT_W'(BUF_N))

endmodule

// ----- rtl/imf_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_seq
// Query sequencer: walks the window, issues pixel reads, drives the sort
// cells, selects the median rank and holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imf_seq #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256,
    parameter int MAX_RADIUS   = 3,
    parameter int ADDR_W       = 16,
    parameter int BUF_N        = 49
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [imf_pkg::PIX_W-1:0]  i_col,
    input  logic [imf_pkg::PIX_W-1:0]  i_row,
    input  logic [imf_pkg::RAD_W-1:0]  i_radius,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [ADDR_W-1:0]          o_rd_addr,
    output imf_pkg::t_sort_ctl         o_sort_ctl,
    input  logic [imf_pkg::PIX_W-1:0]  i_sort_head,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [imf_pkg::PIX_W-1:0]  o_median,
    output logic [imf_pkg::CNT_W-1:0]  o_window_count
);

    localparam int OW = imf_pkg::OFS_W;
    localparam int CW = imf_pkg::CRD_W;
    localparam int NW = imf_pkg::CNT_W;

    imf_pkg::t_state r_state, n_state;

    logic [imf_pkg::PIX_W-1:0] r_col, r_row;
    logic signed [OW-1:0]      r_rad, r_dx, r_dy;
    logic signed [OW-1:0]      n_rad, n_dx, n_dy;
    logic [NW-1:0]             r_cnt, n_cnt;
    logic [NW-1:0]             r_left, n_left;
    logic                      r_rd_vld, n_rd_vld;
    logic                      r_out_vld, n_out_vld;
    logic [imf_pkg::PIX_W-1:0] r_median, n_median;
    logic [NW-1:0]             r_wcnt, n_wcnt;

    logic [CW-1:0]             px, py;
    logic                      in_img;
    logic                      out_free;
    logic                      shift_dec;
    logic [OW-1:0]             rad_eff;

    // clamp the configured radius to the built window size
    assign rad_eff = ({{(OW-imf_pkg::RAD_W){1'b0}}, i_radius} > OW'(MAX_RADIUS))
                   ? OW'(MAX_RADIUS) : {{(OW-imf_pkg::RAD_W){1'b0}}, i_radius};

    assign px = {{(CW-imf_pkg::PIX_W){1'b0}}, r_col} + {{(CW-OW){r_dx[OW-1]}}, r_dx};
    assign py = {{(CW-imf_pkg::PIX_W){1'b0}}, r_row} + {{(CW-OW){r_dy[OW-1]}}, r_dy};

    assign in_img = !px[CW-1] && !py[CW-1]
                  && (32'(px[CW-2:0]) < 32'(IMAGE_WIDTH))
                  && (32'(py[CW-2:0]) < 32'(IMAGE_HEIGHT));

    assign o_rd_addr = ADDR_W'(32'(py[CW-2:0]) * 32'(IMAGE_WIDTH) + 32'(px[CW-2:0]));
    assign out_free  = !r_out_vld || !i_out_stall;
    assign shift_dec = (r_state == imf_pkg::ST_SHIFT) && (r_left != '0);

    always_comb begin
        n_state    = r_state;
        n_rad      = r_rad;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_rd_vld   = 1'b0;
        n_out_vld  = r_out_vld && i_out_stall;
        n_median   = r_median;
        n_wcnt     = r_wcnt;
        o_rd_en    = 1'b0;
        o_sort_ctl = '{clear: 1'b0, insert: r_rd_vld, shift: 1'b0};

        unique case (r_state)
            imf_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_sort_ctl.clear = 1'b1;
                    n_rad   = rad_eff;
                    n_dx    = -rad_eff;
                    n_dy    = -rad_eff;
                    n_cnt   = '0;
                    n_state = imf_pkg::ST_SCAN;
                end
            end
            imf_pkg::ST_SCAN: begin
                o_rd_en  = in_img;
                n_rd_vld = in_img;
                n_cnt    = r_cnt + NW'(in_img);
                if (r_dx == r_rad) begin
                    n_dx = -r_rad;
                    n_dy = r_dy + OW'(1);
                    if (r_dy == r_rad) begin
                        n_state = imf_pkg::ST_FLUSH;
                    end
                end else begin
                    n_dx = r_dx + OW'(1);
                end
            end
            imf_pkg::ST_FLUSH: begin
                // last read lands in the sort cells this cycle
                n_left  = r_cnt >> 1;
                n_state = imf_pkg::ST_SHIFT;
            end
            imf_pkg::ST_SHIFT: begin
                if (r_left == '0) begin
                    n_state = imf_pkg::ST_DONE;
                end else begin
                    o_sort_ctl.shift = 1'b1;
                    n_left = r_left - NW'(1);
                end
            end
            imf_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_median  = (r_cnt == '0) ? '0 : i_sort_head;
                    n_wcnt    = r_cnt;
                    n_state   = imf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = imf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
            r_left    <= '0;
            r_rad     <= '0;
            r_dx      <= '0;
            r_dy      <= '0;
        end else begin
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_rad     <= n_rad;
            r_dx      <= n_dx;
            r_dy      <= n_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        r_median <= n_median;
        r_wcnt   <= n_wcnt;
    end

    assign o_busy         = (r_state != imf_pkg::ST_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_median       = r_median;
    assign o_window_count = r_wcnt;

    `IMF_ASSERT_IMP(a_seq_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= NW'(BUF_N))
    `IMF_ASSERT_IMP(a_seq_start_idle, i_clk, i_rst_n, i_start, r_state == imf_pkg::ST_IDLE)
    `IMF_ASSERT_NEXT(a_seq_left_dec, i_clk, i_rst_n, shift_dec, r_left == $past(r_left) - NW'(1))

endmodule

// ----- rtl/image_median_filter_core.sv -----
// Write transaction: accepted whenever the core is not busy, no result. Query transaction: scans
// the window, one position per cycle, inserting each in-image pixel into the sort cells, then
// shifts out count/2 entries, one per cycle, and loads the median once the result register is free.
// The core goes idle as the result loads, so the next transaction is accepted even while it waits.
// Synchronous active-low reset clears control state and sets the radius to 2; pixels are not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_median_filter_core
// 2-D median filter over a stored 8-bit grayscale image.
// ----------------------------------------------------------------------------
module image_median_filter_core #(
    parameter int IMAGE_WIDTH  = 256,
    parameter int IMAGE_HEIGHT = 256,
    parameter int MAX_RADIUS   = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_func,
    input  logic [imf_pkg::PIX_W-1:0]  i_col,
    input  logic [imf_pkg::PIX_W-1:0]  i_row,
    input  logic [imf_pkg::PIX_W-1:0]  i_pixel,
    input  logic                       i_cfg_we,
    input  logic [imf_pkg::RAD_W-1:0]  i_cfg_wdata,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [imf_pkg::PIX_W-1:0]  o_median,
    output logic [imf_pkg::CNT_W-1:0]  o_window_count
);

    localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EFF_R  = (MAX_RADIUS < imf_pkg::RAD_LIMIT) ? MAX_RADIUS
                                                               : imf_pkg::RAD_LIMIT;
    localparam int BUF_N  = (2 * EFF_R + 1) * (2 * EFF_R + 1);

    logic [imf_pkg::RAD_W-1:0] r_window_radius;
    logic                      busy;
    logic                      accept;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [imf_pkg::PIX_W-1:0] rd_data;
    logic [imf_pkg::PIX_W-1:0] sort_head;
    imf_pkg::t_sort_ctl        sort_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_radius <= imf_pkg::RAD_W'(2);
        end else if (i_cfg_we) begin
            r_window_radius <= i_cfg_wdata;
        end
    end

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    // drop writes that fall outside the image
    assign wr_en   = accept && (i_func == imf_pkg::FUNC_WRITE)
                   && (32'(i_col) < 32'(IMAGE_WIDTH)) && (32'(i_row) < 32'(IMAGE_HEIGHT));
    assign wr_addr = ADDR_W'(32'(i_row) * 32'(IMAGE_WIDTH) + 32'(i_col));

    imf_ram #(
        .WIDTH  (imf_pkg::PIX_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_pixel),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    imf_sort #(
        .BUF_N (BUF_N)
    ) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sort_ctl),
        .i_din   (rd_data),
        .o_head  (sort_head)
    );

    imf_seq #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .MAX_RADIUS   (MAX_RADIUS),
        .ADDR_W       (ADDR_W),
        .BUF_N        (BUF_N)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (accept && (i_func == imf_pkg::FUNC_QUERY)),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_radius       (r_window_radius),
        .o_busy         (busy),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .o_sort_ctl     (sort_ctl),
        .i_sort_head    (sort_head),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median       (o_median),
        .o_window_count (o_window_count)
    );

endmodule

// ----- tb/image_median_filter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_median_filter_core_tb
// Self-checking bench for the median filter core. A local image copy and
// window sorter predict every query; pixels are always written before any
// query window covers them. Directed corner cases come first, then random
// fill/query/overwrite traffic at every radius with random idling on both
// channels.
// ----------------------------------------------------------------------------
module image_median_filter_core_tb;
    import imf_pkg::*;

    localparam int IMG_W         = 256;
    localparam int IMG_H         = 256;
    localparam int MAX_RAD       = 3;
    localparam int WIN_MAX       = (2 * MAX_RAD + 1) * (2 * MAX_RAD + 1);
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 315;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic [CNT_W-1:0] count;
    } t_median_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_func      = FUNC_WRITE;
    logic [PIX_W-1:0]   i_col       = '0;
    logic [PIX_W-1:0]   i_row       = '0;
    logic [PIX_W-1:0]   i_pixel     = '0;
    logic               i_cfg_we    = 1'b0;
    logic [RAD_W-1:0]   i_cfg_wdata = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [PIX_W-1:0]   o_median;
    logic [CNT_W-1:0]   o_window_count;

    // local copy of the image and the radius register
    logic [PIX_W-1:0]   img_mem     [0:IMG_W*IMG_H-1];
    bit                 img_written [0:IMG_W*IMG_H-1];
    logic [RAD_W-1:0]   win_radius = RAD_W'(2);

    t_median_result     pending_medians[$];
    int                 error_count = 0;
    int                 items_sent  = 0;
    int                 cycle_count = 0;
    bit                 no_idle     = 1'b0;
    int                 col_anchor;
    int                 row_anchor;

    image_median_filter_core #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H),
        .MAX_RADIUS   (MAX_RAD)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_pixel        (i_pixel),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median       (o_median),
        .o_window_count (o_window_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_median_result predict_median(input logic [PIX_W-1:0] col,
                                                      input logic [PIX_W-1:0] row);
        logic [PIX_W-1:0] win [WIN_MAX];
        logic [PIX_W-1:0] v;
        t_median_result   res;
        int               n, rad, dx, dy, px, py, j;
        n   = 0;
        rad = (int'(win_radius) > MAX_RAD) ? MAX_RAD : int'(win_radius);
        for (dy = -rad; dy <= rad; dy++) begin
            for (dx = -rad; dx <= rad; dx++) begin
                px = int'(col) + dx;
                py = int'(row) + dy;
                if (px >= 0 && px < IMG_W && py >= 0 && py < IMG_H && n < WIN_MAX) begin
                    win[n] = img_mem[py * IMG_W + px];
                    n++;
                end
            end
        end
        // insertion sort, ascending
        for (int a = 1; a < n; a++) begin
            v = win[a];
            j = a;
            while (j > 0 && win[j-1] > v) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = v;
        end
        res.median = (n == 0) ? '0 : win[n / 2];
        res.count  = CNT_W'(n);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_median_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_medians.size() == 0) begin
                report_mismatch($sformatf("unexpected result median=%0d count=%0d",
                                          o_median, o_window_count));
            end else begin
                exp_res = pending_medians.pop_front();
                if (o_median !== exp_res.median)
                    report_mismatch($sformatf("median got %0d want %0d",
                                              o_median, exp_res.median));
                if (o_window_count !== exp_res.count)
                    report_mismatch($sformatf("window_count got %0d want %0d",
                                              o_window_count, exp_res.count));
            end
        end
    end

    // result side: hold stall for a random number of cycles before each result is taken
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic send_txn(input logic func, input int col, input int row,
                            input logic [PIX_W-1:0] pixel);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func     = func;
        i_col      = PIX_W'(col);
        i_row      = PIX_W'(row);
        i_pixel    = pixel;
        do @(posedge i_clk); while (o_in_stall);
        if (func == FUNC_WRITE) begin
            if (col < IMG_W && row < IMG_H) begin
                img_mem[row * IMG_W + col]     = pixel;
                img_written[row * IMG_W + col] = 1'b1;
            end
        end else begin
            pending_medians.push_back(predict_median(PIX_W'(col), PIX_W'(row)));
        end
        items_sent++;
    endtask

    // drop valid, wait for all results, then let any trailing write settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input int value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = RAD_W'(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        win_radius  = RAD_W'(value);
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            1:       return PIX_W'($urandom_range(120, 135));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // write every unwritten pixel of the window, then query its center
    task automatic fill_and_query(input int col, input int row);
        int rad, dx, dy, px, py;
        rad = int'(win_radius);
        for (dy = -rad; dy <= rad; dy++) begin
            for (dx = -rad; dx <= rad; dx++) begin
                px = col + dx;
                py = row + dy;
                if (px >= 0 && px < IMG_W && py >= 0 && py < IMG_H
                    && !img_written[py * IMG_W + px])
                    send_txn(FUNC_WRITE, px, py, draw_pixel());
            end
        end
        send_txn(FUNC_QUERY, col, row, PIX_W'($urandom_range(0, 255)));
    endtask

    function automatic int pick_coord(input int anchor, input int limit);
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(limit - 3, limit - 1);
            default: return anchor + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    task automatic test_default_radius();
        logic [PIX_W-1:0] corner_vals [9] = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd255,
                                              8'd3, 8'd128, 8'd0, 8'd90};
        for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 3; dx++)
                send_txn(FUNC_WRITE, dx, dy, corner_vals[dy * 3 + dx]);
        // radius 2 from reset: nine pixels at the top-left corner
        send_txn(FUNC_QUERY, 0, 0, 8'hFF);
    endtask

    task automatic test_small_windows();
        write_radius(0);
        send_txn(FUNC_QUERY, 0, 0, 8'h00);
        send_txn(FUNC_WRITE, 255, 255, 8'd255);
        send_txn(FUNC_QUERY, 255, 255, 8'hAA);
        write_radius(1);
        send_txn(FUNC_WRITE, 254, 254, 8'd1);
        send_txn(FUNC_WRITE, 255, 254, 8'd254);
        send_txn(FUNC_WRITE, 254, 255, 8'd127);
        // even count at a corner: upper median
        send_txn(FUNC_QUERY, 255, 255, 8'h55);
        send_txn(FUNC_QUERY, 0, 0, 8'h0F);
    endtask

    task automatic test_full_window_corner();
        write_radius(MAX_RAD);
        fill_and_query(0, 0);
    endtask

    task automatic test_random_traffic(input int radius, input int n_items);
        int target, next_toggle, sel, c, r;
        write_radius(radius);
        target      = items_sent + n_items;
        next_toggle = items_sent + 150;
        while (items_sent < target) begin
            if (items_sent >= next_toggle) begin
                next_toggle = items_sent + 150;
                no_idle     = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    drain_results();
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                fill_and_query(pick_coord(col_anchor, IMG_W), pick_coord(row_anchor, IMG_H));
            end else if (sel < 85) begin
                // overwrite near a hot spot so old windows change content
                c = pick_coord(col_anchor, IMG_W) + $urandom_range(0, 6) - 3;
                r = pick_coord(row_anchor, IMG_H) + $urandom_range(0, 6) - 3;
                c = (c < 0) ? 0 : (c >= IMG_W) ? IMG_W - 1 : c;
                r = (r < 0) ? 0 : (r >= IMG_H) ? IMG_H - 1 : r;
                send_txn(FUNC_WRITE, c, r, draw_pixel());
            end else begin
                send_txn(FUNC_WRITE, int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                         PIX_W'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    = 1'b1;
        col_anchor = $urandom_range(8, IMG_W - 9);
        row_anchor = $urandom_range(8, IMG_H - 9);

        test_default_radius();
        test_small_windows();
        test_full_window_corner();
        test_random_traffic(MAX_RAD, PHASE_ITEMS);
        test_random_traffic(0, PHASE_ITEMS);
        test_random_traffic(1, PHASE_ITEMS);
        test_random_traffic(2, PHASE_ITEMS);
        test_random_traffic($urandom_range(0, 3), PHASE_ITEMS);

        drain_results();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- image_median_filter_core.f -----
+incdir+rtl
rtl/imf_pkg.sv
rtl/imf_ram.sv
rtl/imf_sort.sv
rtl/imf_seq.sv
rtl/image_median_filter_core.sv
tb/image_median_filter_core_tb.sv
